@@ design/bsce_pkg.sv @@
package bsce_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_POLYNOMIAL  = 2'd0;
  localparam logic [1:0] CFG_ORDER_BYTES = 2'd1;
  localparam logic [1:0] CFG_ATTACH_MODE = 2'd2;

  // Reset values of the configuration registers
  localparam logic [32:0] POLY_RESET        = 33'h001864CFB;
  localparam logic [2:0]  ORDER_BYTES_RESET = 3'd3;

  localparam int CRC_W = 32;

  // Order code: 0..3 selects order 8, 16, 24, 32
  typedef logic [1:0] order_code_t;

  // Result job handed from the update stage to the output stage
  typedef struct packed {
    logic [CRC_W-1:0] crc;
    order_code_t      order;
    logic             attach;
  } crc_job_t;

  // Saturate the byte count of the order to 1..4, return as 0..3
  function automatic order_code_t order_code(input logic [2:0] ob);
    order_code_t c;
    c = 2'd0;
    unique case (ob)
      3'd0, 3'd1: c = 2'd0;
      3'd2:       c = 2'd1;
      3'd3:       c = 2'd2;
      default:    c = 2'd3;
    endcase
    return c;
  endfunction

  // Mask of the active CRC bits for an order code
  function automatic logic [CRC_W-1:0] order_mask(input order_code_t c);
    logic [CRC_W-1:0] m;
    m = '1;
    unique case (c)
      2'd0:    m = 32'h0000_00FF;
      2'd1:    m = 32'h0000_FFFF;
      2'd2:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Top bit of the remainder for an order code
  function automatic logic crc_top(input logic [CRC_W-1:0] crc, input order_code_t c);
    logic t;
    t = 1'b0;
    unique case (c)
      2'd0:    t = crc[7];
      2'd1:    t = crc[15];
      2'd2:    t = crc[23];
      default: t = crc[31];
    endcase
    return t;
  endfunction

endpackage

@@ design/bsce_state_mem.sv @@
module bsce_state_mem
  import bsce_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [CRC_W-1:0] wdata,
  output logic [CRC_W-1:0] rdata
);

  // Remainder store: one entry, synchronous write, registered read
  logic [CRC_W-1:0] mem [1];
  logic [CRC_W-1:0] rd_q_r;
  logic             valid_r;
  logic             fwd_r;
  logic [CRC_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[0] <= wdata;
    end
    rd_q_r     <= mem[0];
    fwd_data_r <= wdata;
  end

  // Entry valid bit and write-to-read forwarding flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      if (we) begin
        valid_r <= 1'b1;
      end
      fwd_r <= we;
    end
  end

  // The registered read lags one write behind; forward that write
  always_comb begin
    if (fwd_r) begin
      rdata = fwd_data_r;
    end else if (valid_r) begin
      rdata = rd_q_r;
    end else begin
      rdata = '0;
    end
  end

  a_fwd_matches_write: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> rdata == $past(wdata))
    else $error("state read does not return the last written remainder");

endmodule

@@ design/bsce_update.sv @@
module bsce_update
  import bsce_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input transaction
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  input  logic [3:0]       bit_count,
  input  logic             last_item,
  // configuration
  input  logic [32:0]      poly_cfg,
  input  logic [2:0]       order_bytes_cfg,
  input  logic             attach_cfg,
  // state memory
  output logic             mem_we,
  output logic [CRC_W-1:0] mem_wdata,
  input  logic [CRC_W-1:0] mem_rdata,
  // result job
  output logic             job_valid,
  input  logic             job_ready,
  output crc_job_t         job
);

  logic             s1_valid_r;
  logic [7:0]       s1_data_r;
  logic [3:0]       s1_count_r;
  logic             s1_last_r;
  logic             s1_adv;
  logic [3:0]       count_sat;
  order_code_t      ocode;
  logic [CRC_W-1:0] mask;
  logic [CRC_W-1:0] poly;
  logic [CRC_W-1:0] crc_new;
  logic             fb;

  assign s1_adv   = s1_valid_r && (!s1_last_r || job_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  // Input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r  <= data_byte;
      s1_count_r <= bit_count;
      s1_last_r  <= last_item;
    end
  end

  // Bit-serial LFSR steps over the valid leading bits of the byte
  always_comb begin
    ocode     = order_code(order_bytes_cfg);
    mask      = order_mask(ocode);
    poly      = poly_cfg[CRC_W-1:0] & mask;
    count_sat = (s1_count_r > 4'd8) ? 4'd8 : s1_count_r;
    crc_new   = mem_rdata & mask;
    fb        = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < count_sat) begin
        fb      = crc_top(crc_new, ocode) ^ s1_data_r[7-k];
        crc_new = (crc_new << 1) & mask;
        if (fb) begin
          crc_new = crc_new ^ poly;
        end
      end
    end
  end

  // Write back; the remainder clears at the end of a message
  assign mem_we    = s1_adv;
  assign mem_wdata = s1_last_r ? '0 : crc_new;

  assign job_valid  = s1_valid_r && s1_last_r;
  assign job.crc    = crc_new;
  assign job.order  = ocode;
  assign job.attach = attach_cfg;

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> mem_rdata == '0)
    else $error("remainder not cleared after the last transaction");

  a_stall_only_on_job: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !in_ready |-> s1_last_r && !job_ready)
    else $error("update stage stalled without a blocked result");

endmodule

@@ design/bsce_emit.sv @@
module bsce_emit
  import bsce_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  crc_job_t         job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CRC_W-1:0] crc_value,
  output logic             crc_bit,
  output logic             final_result
);

  logic             busy_r;
  logic             attach_r;
  logic [CRC_W-1:0] crc_r;
  logic [4:0]       idx_r;
  logic             beat_done;
  logic             is_final;

  assign out_valid = busy_r;
  assign beat_done = busy_r && out_ready;
  assign is_final  = !attach_r || (idx_r == 5'd0);
  assign job_ready = !busy_r || (beat_done && is_final);

  // Result serializer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (job_valid && job_ready) begin
      busy_r <= 1'b1;
    end else if (beat_done && is_final) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      crc_r    <= job.crc;
      attach_r <= job.attach;
      idx_r    <= {job.order, 3'b111};
    end else if (beat_done) begin
      idx_r <= idx_r - 5'd1;
    end
  end

  // Output fields: word mode gives the CRC, attach mode one bit per transaction
  assign crc_value    = attach_r ? '0 : crc_r;
  assign crc_bit      = attach_r ? crc_r[idx_r] : 1'b0;
  assign final_result = is_final;

  a_take_job_busy: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job_ready |=> busy_r)
    else $error("serializer did not start on a taken result");

  a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
    beat_done && is_final && !job_valid |=> !busy_r)
    else $error("serializer stayed busy after its final transaction");

endmodule

@@ design/bit_stream_crc_engine.sv @@
// MSB-first CRC engine with a configurable polynomial of order 8 to 32.
// Input stream: one transaction per message byte. in_tdata carries the byte
// (first message bit in bit 7) and the count of valid leading bits; in_tlast
// marks the final byte of a message. Output stream: on each message end the
// CRC comes either as one word transaction, or in attach mode as one
// transaction per CRC bit, MSB first, out_tlast on the last bit.
// Configuration: cfg_we writes register cfg_index (0 polynomial, 1 order in
// bytes, 2 attach mode) from cfg_wdata; write only while idle.
// Throughput: one input byte per cycle unless in_tready is low. The remainder
// lives in a one-entry store read every cycle, with the previous write
// forwarded, so back-to-back bytes update without bubbles. A last byte is
// registered in the input stage; out_tvalid rises once the output stage has
// registered its result. In attach mode the output stage sends the result
// bit by bit, which then bounds the message rate.
// Reset (rst_n, synchronous) clears the remainder and loads the register
// defaults. When out_tready is low the output holds and, once the pending
// result and one more last byte are queued, in_tready drops.
module bit_stream_crc_engine
  import bsce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [11:8] bit_count, [15:12] zero
  input  logic        in_tlast,   // last_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] crc_value, [32] crc_bit, [39:33] zero
  output logic        out_tlast,  // final_result
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [32:0] cfg_wdata
);

  logic [32:0]      poly_r;
  logic [2:0]       order_bytes_r;
  logic             attach_r;
  logic             mem_we;
  logic [CRC_W-1:0] mem_wdata;
  logic [CRC_W-1:0] mem_rdata;
  logic             job_valid;
  logic             job_ready;
  crc_job_t         job;
  logic [CRC_W-1:0] crc_value;
  logic             crc_bit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r        <= POLY_RESET;
      order_bytes_r <= ORDER_BYTES_RESET;
      attach_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLYNOMIAL:  poly_r        <= cfg_wdata;
        CFG_ORDER_BYTES: order_bytes_r <= cfg_wdata[2:0];
        CFG_ATTACH_MODE: attach_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  bsce_state_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  bsce_update u_update (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .data_byte       (in_tdata[7:0]),
    .bit_count       (in_tdata[11:8]),
    .last_item       (in_tlast),
    .poly_cfg        (poly_r),
    .order_bytes_cfg (order_bytes_r),
    .attach_cfg      (attach_r),
    .mem_we          (mem_we),
    .mem_wdata       (mem_wdata),
    .mem_rdata       (mem_rdata),
    .job_valid       (job_valid),
    .job_ready       (job_ready),
    .job             (job)
  );

  bsce_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .crc_value    (crc_value),
    .crc_bit      (crc_bit),
    .final_result (out_tlast)
  );

  assign out_tdata = {7'd0, crc_bit, crc_value};

endmodule

@@ tb/tb_bit_stream_crc_engine.sv @@
`timescale 1ns / 1ps

module tb_bit_stream_crc_engine;
  import bsce_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] data_byte, [11:8] bit_count, [15:12] zero
  logic        in_tlast = 1'b0; // last_item
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [31:0] crc_value, [32] crc_bit, [39:33] zero
  logic        out_tlast;       // final_result
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [32:0] cfg_wdata = '0;

  // Flow control knobs, percent of idle cycles
  int   sender_idle_pct = 0;
  int   receiver_idle_pct = 0;
  logic hold_off = 1'b0;

  bit_stream_crc_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  typedef struct {
    logic [31:0] crc_value;
    logic        crc_bit;
    logic        final_result;
  } crc_result_t;

  // CRC predictor plus queue of expected results
  class crc_scoreboard;
    logic [32:0]  poly_reg;
    logic [2:0]   order_bytes_reg;
    logic         attach_reg;
    logic [31:0]  remainder;
    crc_result_t  expected_crcs[$];
    int           error_count;
    int           byte_count;
    int           message_count;
    int           result_count;
    int           setting_count;

    function new();
      poly_reg = POLY_RESET;
      order_bytes_reg = ORDER_BYTES_RESET;
      attach_reg = 1'b0;
      remainder = '0;
      error_count = 0;
      byte_count = 0;
      message_count = 0;
      result_count = 0;
      setting_count = 0;
    endfunction

    function void set_register(input logic [1:0] index, input logic [32:0] value);
      case (index)
        CFG_POLYNOMIAL:  poly_reg = value;
        CFG_ORDER_BYTES: order_bytes_reg = value[2:0];
        CFG_ATTACH_MODE: attach_reg = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_crcs.size();
    endfunction

    // Shift the valid bits of one accepted byte into the remainder
    function void note_input(input logic [7:0] data, input logic [3:0] count,
                             input logic last);
      int          order;
      int          nbits;
      logic [31:0] mask;
      logic [31:0] taps;
      logic [31:0] crc;
      logic        top;
      crc_result_t r;
      byte_count++;
      if (order_bytes_reg == 3'd0) order = 8;
      else if (order_bytes_reg > 3'd4) order = 32;
      else order = 8 * order_bytes_reg;
      mask = 32'hFFFF_FFFF >> (32 - order);
      taps = poly_reg[31:0] & mask;
      crc = remainder & mask;
      nbits = (count > 4'd8) ? 8 : count;
      for (int k = 0; k < nbits; k++) begin
        top = crc[order-1];
        crc = (crc << 1) & mask;
        if (top ^ data[7-k]) crc = crc ^ taps;
      end
      remainder = crc;
      if (!last) return;
      message_count++;
      if (!attach_reg) begin
        r.crc_value = crc;
        r.crc_bit = 1'b0;
        r.final_result = 1'b1;
        expected_crcs.push_back(r);
      end else begin
        // serial form, MSB first
        for (int k = 0; k < order; k++) begin
          r.crc_value = '0;
          r.crc_bit = crc[order-1-k];
          r.final_result = (k == order - 1);
          expected_crcs.push_back(r);
        end
      end
      remainder = '0;
    endfunction

    function void check_result(input logic [31:0] crc_value, input logic crc_bit,
                               input logic final_result);
      crc_result_t e;
      if (expected_crcs.size() == 0) begin
        $error("result with none expected: crc_value %h crc_bit %b final_result %b",
               crc_value, crc_bit, final_result);
        error_count++;
        return;
      end
      e = expected_crcs.pop_front();
      result_count++;
      if (crc_value !== e.crc_value) begin
        $error("crc_value mismatch: expected %h, actual %h", e.crc_value, crc_value);
        error_count++;
      end
      if (crc_bit !== e.crc_bit) begin
        $error("crc_bit mismatch: expected %b, actual %b", e.crc_bit, crc_bit);
        error_count++;
      end
      if (final_result !== e.final_result) begin
        $error("final_result mismatch: expected %b, actual %b", e.final_result,
               final_result);
        error_count++;
      end
    endfunction

    function void flag_leftover();
      if (expected_crcs.size() != 0) begin
        $error("%0d expected results never arrived", expected_crcs.size());
        error_count++;
      end
    endfunction
  endclass

  crc_scoreboard sb;

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[31:0], out_tdata[32], out_tlast);
  end

  // Long receiver stall so the block fills and drops in_tready
  task automatic hold_receiver(input int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  // Write all three registers, one per cycle
  task automatic configure(input logic [32:0] poly, input logic [2:0] ob,
                           input logic attach);
    cfg_we <= 1'b1;
    cfg_index <= CFG_POLYNOMIAL;
    cfg_wdata <= poly;
    @(posedge clk);
    sb.set_register(CFG_POLYNOMIAL, poly);
    cfg_index <= CFG_ORDER_BYTES;
    cfg_wdata <= {30'd0, ob};
    @(posedge clk);
    sb.set_register(CFG_ORDER_BYTES, {30'd0, ob});
    cfg_index <= CFG_ATTACH_MODE;
    cfg_wdata <= {32'd0, attach};
    @(posedge clk);
    sb.set_register(CFG_ATTACH_MODE, {32'd0, attach});
    cfg_we <= 1'b0;
    sb.setting_count++;
  endtask

  // Offer one byte, idling cycle by cycle first, and wait for the transaction
  task automatic send_byte(input logic [7:0] data, input logic [3:0] count,
                           input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, count, data};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_input(data, count, last);
  endtask

  // Stop offering and wait until every expected result is back or the limit runs out
  task automatic drain(input int limit);
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (sb.pending() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  // Random message: mostly well-formed, some odd counts and stray lasts
  task automatic send_random_message(inout int budget);
    int len;
    if ($urandom_range(99) < 85) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len - 1; i++) send_byte(8'($urandom_range(255)), 4'd8, 1'b0);
      send_byte(8'($urandom_range(255)), 4'($urandom_range(1, 8)), 1'b1);
      budget -= len;
    end else begin
      send_byte(8'($urandom_range(255)), 4'($urandom_range(15)), 1'($urandom_range(1)));
      budget -= 1;
    end
  endtask

  initial begin
    logic [32:0] poly;
    logic [2:0]  ob;
    logic        attach;
    int          budget;
    sb = new();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 29;
    receiver_idle_pct <= 81;

    // Directed: order 8, all-ones and all-zeros bytes, empty and saturated counts
    configure(33'h0_0000_0107, 3'd1, 1'b0);
    send_byte(8'hFF, 4'd8, 1'b0);
    send_byte(8'h00, 4'd8, 1'b1);
    send_byte(8'h5A, 4'd0, 1'b1);
    send_byte(8'hA5, 4'd15, 1'b1);
    send_byte(8'h5A, 4'd9, 1'b1);
    drain(100000);

    // Order 32 with the top term present, partial last byte
    configure(33'h1_04C1_1DB7, 3'd4, 1'b0);
    send_byte(8'h31, 4'd8, 1'b0);
    send_byte(8'h32, 4'd8, 1'b0);
    send_byte(8'h33, 4'd8, 1'b0);
    send_byte(8'h34, 4'd8, 1'b1);
    send_byte(8'h80, 4'd1, 1'b1);
    drain(100000);

    // Serial output, order byte count above range saturates, all-ones polynomial
    configure(33'h1_FFFF_FFFF, 3'd7, 1'b1);
    send_byte(8'hC3, 4'd8, 1'b0);
    send_byte(8'h7E, 4'd4, 1'b1);
    drain(100000);

    // Zero order byte count means order 8, zero polynomial
    configure(33'h0_0000_0000, 3'd0, 1'b1);
    send_byte(8'hFF, 4'd8, 1'b1);
    drain(100000);

    // Settings changed in the middle of a message
    configure(33'h0_0001_8005, 3'd2, 1'b0);
    send_byte(8'h12, 4'd8, 1'b0);
    send_byte(8'h34, 4'd8, 1'b0);
    drain(100000);
    configure(POLY_RESET, ORDER_BYTES_RESET, 1'b1);
    send_byte(8'h56, 4'd6, 1'b1);
    drain(100000);

    // Random segments, each under its own settings
    for (int seg = 0; seg < 10; seg++) begin
      if (seg == 4) begin
        sender_idle_pct = 81;
        receiver_idle_pct <= 29;
      end else if (seg == 7) begin
        sender_idle_pct = 0;
        receiver_idle_pct <= 0;
      end
      poly[31:0] = $urandom();
      poly[32] = 1'($urandom_range(1));
      ob = 3'($urandom_range(7));
      attach = ($urandom_range(2) == 0);
      if (seg == 1) attach = 1'b1;
      configure(poly, ob, attach);
      if (seg == 1) begin
        fork
          hold_receiver(400);
        join_none
      end
      budget = 25;
      while (budget > 0) send_random_message(budget);
      drain(100000);
    end

    drain(100000);
    sb.flag_leftover();
    $display("Covered %0d bytes in %0d messages and checked %0d results", sb.byte_count,
             sb.message_count, sb.result_count);
    $display("under %0d register settings, word and serial output, stalls on both sides",
             sb.setting_count);
    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
